### rtl/ascii_unsigned_integer_parser_assert.svh
// assertion helpers used by the parser rtl
`ifndef ASCII_UNSIGNED_INTEGER_PARSER_ASSERT_SVH
`define ASCII_UNSIGNED_INTEGER_PARSER_ASSERT_SVH

// same-cycle implication
`define AUP_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("parser assertion failed");

// next-cycle implication
`define AUP_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("parser assertion failed");

`endif

### rtl/aup_pkg.sv
package aup_pkg;

    localparam int VALUE_BITS     = 64;
    localparam int COUNT_BITS     = 16;
    localparam int RADIX_BITS     = 5;
    localparam int WIDTH_BITS     = 16;
    localparam int CHAR_BITS      = 8;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIX_MODE  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH_LIMIT = 1'd1;

    localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 5'd0;
    localparam logic [RADIX_BITS-1:0] RADIX_OCT  = 5'd8;
    localparam logic [RADIX_BITS-1:0] RADIX_DEC  = 5'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_HEX  = 5'd16;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_X_LO = 8'h78;
    localparam logic [CHAR_BITS-1:0] CHAR_X_UP = 8'h58;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_in;
        logic                 field_start;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] number_value;
        logic [COUNT_BITS-1:0] digit_count;
        logic [COUNT_BITS-1:0] consumed_count;
        logic [RADIX_BITS-1:0] radix_used;
        logic                  overflowed;
    } out_item_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    typedef struct packed {
        logic hit;
        logic ovf;
    } mac_status_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_ZERO   = 3'b100
    } phase_t;

    function automatic digit_t digit_of(input logic [CHAR_BITS-1:0] c);
        digit_t d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            d.val = 4'(c - 8'h30);
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            d.val = 4'(c - 8'h57);
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d.val = 4'(c - 8'h37);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    // saturating count increment
    function automatic logic [COUNT_BITS-1:0] cnt_add(input logic [COUNT_BITS-1:0] v,
                                                      input logic [1:0] by);
        logic [COUNT_BITS:0] s;
        s = {1'b0, v} + (COUNT_BITS+1)'(by);
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    // width budget, floors at zero
    function automatic logic [WIDTH_BITS-1:0] width_take(input logic [WIDTH_BITS-1:0] v,
                                                         input logic [1:0] by);
        logic [WIDTH_BITS-1:0] b;
        b = WIDTH_BITS'(by);
        return (v > b) ? (v - b) : {WIDTH_BITS{1'b0}};
    endfunction

endpackage

### rtl/aup_mac.sv
module aup_mac import aup_pkg::*; (
    input  logic [VALUE_BITS-1:0] acc,
    input  logic [RADIX_BITS-1:0] radix,
    input  logic [CHAR_BITS-1:0]  chr,
    output logic [VALUE_BITS-1:0] acc_next,
    output mac_status_t           status
);

    localparam int PW = VALUE_BITS + RADIX_BITS + 1;

    digit_t        dig;
    logic [PW-1:0] prod;

    always_comb
    begin
        dig        = digit_of(chr);
        status.hit = dig.ok && ({1'b0, dig.val} < radix);
        prod       = PW'(acc) * PW'(radix) + PW'(dig.val);
        // anything above the value width means the result no longer fits
        status.ovf = |prod[PW-1:VALUE_BITS];
        acc_next   = status.ovf ? {VALUE_BITS{1'b1}} : prod[VALUE_BITS-1:0];
    end

endmodule

### rtl/aup_out_buf.sv
module aup_out_buf import aup_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_data,
    output logic      full,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_data_reg, out_data_next;
    out_item_t skid_data_reg, skid_data_next;
    logic      pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

### rtl/ascii_unsigned_integer_parser.sv
// channel | direction | handshake          | payload
// in      | into      | in_valid, in_stall  | in_data (char_in, field_start)
// out     | out of    | out_valid, out_stall| out_data (value, counts, radix, flag)
// cfg     | into      | cfg_we              | cfg_index, cfg_data
//
// one character is taken per cycle while in_stall is low; the result for the character
// that ends its number comes from the single radix multiply-add, via the output buffer
// a two-entry output buffer lets input continue while one result waits on out_stall
// in_stall rises only when both output entries are held
// reset: radix_mode 10, width_limit 0, no number active, output empty
`include "ascii_unsigned_integer_parser_assert.svh"

module ascii_unsigned_integer_parser import aup_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_item_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_item_t                 out_data,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [RADIX_BITS-1:0] radix_mode_reg;
    logic [WIDTH_BITS-1:0] width_limit_reg;

    phase_t                phase_reg, phase_next;
    logic                  unb_reg, unb_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [COUNT_BITS-1:0] dig_reg, dig_next;
    logic [COUNT_BITS-1:0] cons_reg, cons_next;
    logic [WIDTH_BITS-1:0] wl_reg, wl_next;
    logic [RADIX_BITS-1:0] radix_reg, radix_next;
    logic                  sat_reg, sat_next;

    // state ahead of the digit step
    logic [VALUE_BITS-1:0] b_acc;
    logic [COUNT_BITS-1:0] b_dig, b_cons;
    logic [WIDTH_BITS-1:0] b_wl;
    logic [RADIX_BITS-1:0] b_radix;
    logic                  b_sat, b_unb;
    phase_t                b_phase;
    logic                  b_step, b_emit;

    logic                  in_fire;
    logic                  is_zero, is_x, prefix_mode;
    logic [VALUE_BITS-1:0] mac_acc;
    mac_status_t           mac_st;
    logic [WIDTH_BITS-1:0] s_wl;
    logic                  push;
    out_item_t             push_data;
    logic                  buf_full;

    assign in_fire     = in_valid && !in_stall;
    assign in_stall    = buf_full;
    assign is_zero     = (in_data.char_in == CHAR_ZERO);
    assign is_x        = (in_data.char_in == CHAR_X_LO) || (in_data.char_in == CHAR_X_UP);
    assign prefix_mode = (radix_mode_reg == RADIX_AUTO) || (radix_mode_reg == RADIX_HEX);

    always_comb
    begin
        b_acc   = acc_reg;
        b_dig   = dig_reg;
        b_cons  = cons_reg;
        b_wl    = wl_reg;
        b_radix = radix_reg;
        b_sat   = sat_reg;
        b_unb   = unb_reg;
        b_phase = phase_reg;
        b_step  = 1'b0;
        b_emit  = 1'b0;
        if (in_fire)
        begin
            if (in_data.field_start)
            begin
                b_acc   = '0;
                b_dig   = '0;
                b_cons  = '0;
                b_sat   = 1'b0;
                b_unb   = (width_limit_reg == '0);
                b_wl    = width_limit_reg;
                b_phase = PH_DIGITS;
                // a leading zero may open a prefix when two characters of width remain
                if (is_zero && prefix_mode && (b_unb || width_limit_reg >= WIDTH_BITS'(2)))
                begin
                    b_phase = PH_ZERO;
                    b_radix = (radix_mode_reg == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
                end
                else
                begin
                    if (radix_mode_reg == RADIX_AUTO)
                    begin
                        b_radix = is_zero ? RADIX_OCT : RADIX_DEC;
                    end
                    else
                    begin
                        b_radix = radix_mode_reg;
                    end
                    b_step = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_ZERO:
                    begin
                        b_phase = PH_DIGITS;
                        if (is_x)
                        begin
                            b_radix = RADIX_HEX;
                            b_cons  = cnt_add(cons_reg, 2'd2);
                            b_wl    = width_take(wl_reg, 2'd2);
                            b_emit  = !unb_reg && (b_wl == '0);
                        end
                        else
                        begin
                            // held zero becomes a digit; this character is tried if width is left
                            b_dig  = cnt_add(dig_reg, 2'd1);
                            b_cons = cnt_add(cons_reg, 2'd1);
                            b_wl   = width_take(wl_reg, 2'd1);
                            b_emit = !unb_reg && (b_wl == '0);
                            b_step = !b_emit;
                        end
                    end
                    PH_DIGITS:
                    begin
                        b_step = 1'b1;
                    end
                    default:
                    begin
                        b_step = 1'b0;
                    end
                endcase
            end
        end
    end

    aup_mac u_mac (
        .acc      (b_acc),
        .radix    (b_radix),
        .chr      (in_data.char_in),
        .acc_next (mac_acc),
        .status   (mac_st)
    );

    assign s_wl = width_take(b_wl, 2'd1);

    always_comb
    begin
        acc_next   = b_acc;
        dig_next   = b_dig;
        cons_next  = b_cons;
        wl_next    = b_wl;
        radix_next = b_radix;
        sat_next   = b_sat;
        unb_next   = b_unb;
        phase_next = b_phase;
        push       = b_emit;
        if (b_step)
        begin
            if (!mac_st.hit)
            begin
                // a non-digit or a digit beyond the radix ends the number, not consumed
                push = 1'b1;
            end
            else
            begin
                acc_next  = mac_acc;
                sat_next  = b_sat || mac_st.ovf;
                dig_next  = cnt_add(b_dig, 2'd1);
                cons_next = cnt_add(b_cons, 2'd1);
                wl_next   = s_wl;
                push      = !b_unb && (s_wl == '0);
            end
        end
        if (push)
        begin
            phase_next = PH_IDLE;
        end
        push_data.number_value   = acc_next;
        push_data.digit_count    = dig_next;
        push_data.consumed_count = cons_next;
        push_data.radix_used     = radix_next;
        push_data.overflowed     = sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_mode_reg  <= RADIX_DEC;
            width_limit_reg <= '0;
            phase_reg       <= PH_IDLE;
            unb_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RADIX_MODE:  radix_mode_reg  <= cfg_data[RADIX_BITS-1:0];
                    CFG_WIDTH_LIMIT: width_limit_reg <= cfg_data[WIDTH_BITS-1:0];
                    default:         radix_mode_reg  <= radix_mode_reg;
                endcase
            end
            phase_reg <= phase_next;
            unb_reg   <= unb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        dig_reg   <= dig_next;
        cons_reg  <= cons_next;
        wl_reg    <= wl_next;
        radix_reg <= radix_next;
        sat_reg   <= sat_next;
    end

    aup_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && in_fire),
        .push_data (push_data),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `AUP_ASSERT_IMPL(a_stall_has_result, clk, rst_n, in_stall, out_valid)
    `AUP_ASSERT_IMPL(a_sat_all_ones, clk, rst_n, out_valid && out_data.overflowed, &out_data.number_value)
    `AUP_ASSERT_IMPL(a_digits_in_consumed, clk, rst_n, out_valid, out_data.digit_count <= out_data.consumed_count)
    `AUP_ASSERT_NEXT(a_zero_waits, clk, rst_n, (phase_reg == PH_ZERO) && !in_fire, phase_reg == PH_ZERO)

endmodule

### sim/tb_ascii_unsigned_integer_parser.sv
`timescale 1ns / 1ps

module tb_ascii_unsigned_integer_parser;
    import aup_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_CHARS  = 330;
    localparam int PHASE_CHARS   = 40;
    localparam int MAX_REPORTS   = 10;
    localparam longint CYCLE_LIMIT = 1000000;

    localparam logic [RADIX_BITS-1:0] RADIX_UNARY = 5'd1;
    localparam logic [RADIX_BITS-1:0] RADIX_BIN   = 5'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_TOP   = 5'd31;
    localparam logic [WIDTH_BITS-1:0] WIDTH_ANY   = 16'd0;
    localparam logic [WIDTH_BITS-1:0] WIDTH_TOP   = 16'hFFFF;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX   = {VALUE_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_TOP   = {COUNT_BITS{1'b1}};

    localparam logic [RADIX_BITS-1:0] RADIX_PLAN [8] = '{RADIX_DEC, RADIX_AUTO, RADIX_HEX,
        RADIX_OCT, RADIX_BIN, RADIX_UNARY, RADIX_TOP, RADIX_AUTO};
    localparam logic [WIDTH_BITS-1:0] WIDTH_PLAN [8] = '{WIDTH_ANY, 16'd2, 16'd1, WIDTH_ANY,
        16'd3, WIDTH_TOP, 16'd5, 16'd2};

    typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct {
        row_kind_t             kind;
        logic [CHAR_BITS-1:0]  ch;
        logic                  fs;
        int                    reps;
        bit                    typed;
        out_item_t             want;
        logic [RADIX_BITS-1:0] radix;
        logic [WIDTH_BITS-1:0] width;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    in_item_t                  in_data;
    logic                      out_valid;
    logic                      out_stall;
    out_item_t                 out_data;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // hand-typed result that the current transfer must end with
    bit        row_typed;
    out_item_t row_want;

    // register copies
    logic [RADIX_BITS-1:0] radix_reg = RADIX_DEC;
    logic [WIDTH_BITS-1:0] width_reg = WIDTH_ANY;

    // parser copy
    bit                    busy      = 1'b0;
    bit                    zero_held = 1'b0;
    bit                    unbounded = 1'b0;
    bit                    sat       = 1'b0;
    logic [VALUE_BITS-1:0] acc       = '0;
    logic [COUNT_BITS-1:0] ndigits   = '0;
    logic [COUNT_BITS-1:0] nconsumed = '0;
    logic [WIDTH_BITS-1:0] budget    = '0;
    logic [RADIX_BITS-1:0] radix_now = '0;

    out_item_t expected_numbers[$];

    int     chars_parsed    = 0;
    int     numbers_checked = 0;
    int     mismatches      = 0;
    int     settings_run    = 0;
    int     burst_left      = 0;
    longint cycles          = 0;

    ascii_unsigned_integer_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v,
                                                   input int n);
        logic [COUNT_BITS:0] s;
        s = {1'b0, v} + (COUNT_BITS+1)'(n);
        return s[COUNT_BITS] ? COUNT_TOP : s[COUNT_BITS-1:0];
    endfunction

    // true when the width budget is used up
    function automatic bit spend(input int n);
        nconsumed = bump(nconsumed, n);
        if (unbounded)
            return 1'b0;
        budget = (budget > WIDTH_BITS'(n)) ? budget - WIDTH_BITS'(n) : '0;
        return budget == '0;
    endfunction

    function automatic int char_digit(input logic [CHAR_BITS-1:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic out_item_t close_number();
        out_item_t r;
        r = {acc, ndigits, nconsumed, radix_now, sat};
        busy = 1'b0;
        zero_held = 1'b0;
        return r;
    endfunction

    function automatic bit take_digit(input logic [CHAR_BITS-1:0] c, output out_item_t res);
        int d;
        logic [VALUE_BITS-1:0] lim;
        res = '0;
        d = char_digit(c);
        if (d < 0 || d >= int'(radix_now))
        begin
            res = close_number();
            return 1'b1;
        end
        lim = (VALUE_MAX - VALUE_BITS'(d)) / VALUE_BITS'(radix_now);
        if (acc > lim)
        begin
            acc = VALUE_MAX;
            sat = 1'b1;
        end
        else
        begin
            acc = acc * VALUE_BITS'(radix_now) + VALUE_BITS'(d);
        end
        ndigits = bump(ndigits, 1);
        if (spend(1))
        begin
            res = close_number();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // returns 1 when the character ends a number, with the result in res
    function automatic bit parse_char(input logic [CHAR_BITS-1:0] c, input logic fs,
                                      output out_item_t res);
        res = '0;
        if (fs)
        begin
            chars_parsed++;
            acc = '0;
            ndigits = '0;
            nconsumed = '0;
            sat = 1'b0;
            zero_held = 1'b0;
            busy = 1'b1;
            unbounded = (width_reg == WIDTH_ANY);
            budget = width_reg;
            if (c == CHAR_ZERO && (radix_reg == RADIX_AUTO || radix_reg == RADIX_HEX)
                && (unbounded || budget >= 16'd2))
            begin
                zero_held = 1'b1;
                radix_now = (radix_reg == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
                return 1'b0;
            end
            if (radix_reg == RADIX_AUTO)
                radix_now = (c == CHAR_ZERO) ? RADIX_OCT : RADIX_DEC;
            else
                radix_now = radix_reg;
            return take_digit(c, res);
        end
        if (!busy)
            return 1'b0;
        chars_parsed++;
        if (zero_held)
        begin
            zero_held = 1'b0;
            if (c == CHAR_X_LO || c == CHAR_X_UP)
            begin
                radix_now = RADIX_HEX;
                if (spend(2))
                begin
                    res = close_number();
                    return 1'b1;
                end
                return 1'b0;
            end
            // the held zero turns out to be a digit
            ndigits = bump(ndigits, 1);
            if (spend(1))
            begin
                res = close_number();
                return 1'b1;
            end
        end
        return take_digit(c, res);
    endfunction

    always @(posedge clk)
    begin : monitor
        out_item_t made;
        out_item_t want;
        bit ended;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_RADIX_MODE)
                    radix_reg = cfg_data[RADIX_BITS-1:0];
                else if (cfg_index == CFG_WIDTH_LIMIT)
                    width_reg = cfg_data[WIDTH_BITS-1:0];
            end
            if (in_valid && !in_stall)
            begin
                ended = parse_char(in_data.char_in, in_data.field_start, made);
                if (row_typed)
                    expected_numbers.push_back(row_want);
                else if (ended)
                    expected_numbers.push_back(made);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_numbers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: value %h digits %0d consumed %0d radix %0d ovf %0b",
                                 out_data.number_value, out_data.digit_count,
                                 out_data.consumed_count, out_data.radix_used,
                                 out_data.overflowed);
                end
                else
                begin
                    want = expected_numbers.pop_front();
                    numbers_checked++;
                    if (out_data.number_value !== want.number_value
                        || out_data.digit_count !== want.digit_count
                        || out_data.consumed_count !== want.consumed_count
                        || out_data.radix_used !== want.radix_used
                        || out_data.overflowed !== want.overflowed)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch exp/act: value %h/%h digits %0d/%0d consumed %0d/%0d radix %0d/%0d ovf %0b/%0b",
                                     want.number_value, out_data.number_value,
                                     want.digit_count, out_data.digit_count,
                                     want.consumed_count, out_data.consumed_count,
                                     want.radix_used, out_data.radix_used,
                                     want.overflowed, out_data.overflowed);
                    end
                end
            end
        end
    end

    initial
    begin : receiver
        stall_mode_t mode;
        int left;
        int tick;
        out_stall = 1'b0;
        mode = STALL_NONE;
        left = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                left = $urandom_range(10, 80);
            end
            left--;
            tick++;
            case (mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 85);
                default:     out_stall <= (tick % 5 != 0);
            endcase
        end
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("FAILURE");
        $finish;
    end

    function automatic out_item_t number(input logic [VALUE_BITS-1:0] v, input int d,
                                         input int n, input logic [RADIX_BITS-1:0] rdx,
                                         input logic o);
        out_item_t r;
        r.number_value = v;
        r.digit_count = COUNT_BITS'(d);
        r.consumed_count = COUNT_BITS'(n);
        r.radix_used = rdx;
        r.overflowed = o;
        return r;
    endfunction

    function automatic stim_row_t char_row(input logic [CHAR_BITS-1:0] ch, input logic fs,
                                           input int reps);
        stim_row_t r;
        r.kind = ROW_CHAR;
        r.ch = ch;
        r.fs = fs;
        r.reps = reps;
        r.typed = 1'b0;
        r.want = '0;
        r.radix = RADIX_DEC;
        r.width = WIDTH_ANY;
        return r;
    endfunction

    function automatic stim_row_t end_row(input logic [CHAR_BITS-1:0] ch, input logic fs,
                                          input out_item_t want);
        stim_row_t r;
        r = char_row(ch, fs, 1);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [RADIX_BITS-1:0] radix,
                                          input logic [WIDTH_BITS-1:0] width);
        stim_row_t r;
        r = char_row(8'h00, 1'b0, 0);
        r.kind = ROW_CFG;
        r.radix = radix;
        r.width = width;
        return r;
    endfunction

    function automatic logic [CHAR_BITS-1:0] digit_char(input int base);
        int lim;
        int d;
        lim = (base > 16) ? 16 : ((base < 1) ? 1 : base);
        d = $urandom_range(0, lim - 1);
        if (d < 10)
            return CHAR_ZERO + CHAR_BITS'(d);
        if ($urandom_range(0, 1) == 0)
            return "a" + CHAR_BITS'(d - 10);
        return "A" + CHAR_BITS'(d - 10);
    endfunction

    task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic fs,
                             input bit typed = 1'b0, input out_item_t want = '0);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= {c, fs};
        row_typed <= typed;
        row_want <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off the sender until every result is back, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        row_typed <= 1'b0;
        while (expected_numbers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input logic [RADIX_BITS-1:0] radix,
                              input logic [WIDTH_BITS-1:0] width);
        cfg_we <= 1'b1;
        cfg_index <= CFG_RADIX_MODE;
        cfg_data <= CFG_DATA_BITS'(radix);
        @(negedge clk);
        cfg_index <= CFG_WIDTH_LIMIT;
        cfg_data <= width;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    task automatic send_random_item();
        int base;
        int len;
        logic [CHAR_BITS-1:0] c;
        if ($urandom_range(0, 99) < 12)
        begin
            send_char(CHAR_BITS'($urandom), $urandom_range(0, 3) == 0);
            return;
        end
        base = (radix_reg == RADIX_AUTO) ? int'(RADIX_DEC) : int'(radix_reg);
        if ((radix_reg == RADIX_AUTO || radix_reg == RADIX_HEX) && $urandom_range(0, 3) == 0)
        begin
            send_char(CHAR_ZERO, 1'b1);
            case ($urandom_range(0, 3))
                0:
                begin
                    send_char(CHAR_X_LO, 1'b0);
                    base = int'(RADIX_HEX);
                end
                1:
                begin
                    send_char(CHAR_X_UP, 1'b0);
                    base = int'(RADIX_HEX);
                end
                default: base = (radix_reg == RADIX_AUTO) ? int'(RADIX_OCT) : int'(RADIX_HEX);
            endcase
        end
        else
        begin
            c = digit_char(base);
            send_char(c, 1'b1);
            if (radix_reg == RADIX_AUTO && c == CHAR_ZERO)
                base = int'(RADIX_OCT);
        end
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(18, 70) : $urandom_range(0, 7);
        repeat (len) send_char(digit_char(base), 1'b0);
        case ($urandom_range(0, 5))
            0: send_char(" ", 1'b0);
            1: send_char(CHAR_BITS'($urandom_range(128, 255)), 1'b0);
            2: send_char(CHAR_BITS'($urandom_range(0, 47)), 1'b0);
            3: send_char(CHAR_BITS'($urandom_range(103, 122)), 1'b0);
            4: send_char(digit_char(16), 1'b0);
            default: ; // left open, the next field start abandons it
        endcase
        if ($urandom_range(0, 4) == 0)
            send_char(CHAR_BITS'($urandom), 1'b0);
    endtask

    initial
    begin : stimulus
        stim_row_t rows[$];
        int start_count;
        int phase_start;
        logic [RADIX_BITS-1:0] radix_pick;
        logic [WIDTH_BITS-1:0] width_pick;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        row_typed = 1'b0;
        row_want = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_RADIX_MODE;
        cfg_data = '0;

        // reset settings: decimal, no width limit
        rows.push_back(char_row("A", 1'b0, 1));
        rows.push_back(char_row("9", 1'b1, 1));
        rows.push_back(end_row(" ", 1'b0, number(9, 1, 1, RADIX_DEC, 1'b0)));
        rows.push_back(char_row("1", 1'b1, 1));
        rows.push_back(char_row("5", 1'b1, 1));
        rows.push_back(end_row(" ", 1'b0, number(5, 1, 1, RADIX_DEC, 1'b0)));
        rows.push_back(char_row("9", 1'b1, 1));
        rows.push_back(char_row("9", 1'b0, 20));
        rows.push_back(end_row(",", 1'b0, number(VALUE_MAX, 21, 21, RADIX_DEC, 1'b1)));
        rows.push_back(end_row(8'hFF, 1'b1, number(0, 0, 0, RADIX_DEC, 1'b0)));
        rows.push_back(cfg_row(RADIX_AUTO, WIDTH_ANY));
        rows.push_back(char_row(CHAR_ZERO, 1'b1, 1));
        rows.push_back(char_row(CHAR_X_LO, 1'b0, 1));
        rows.push_back(char_row("f", 1'b0, 1));
        rows.push_back(end_row(" ", 1'b0, number(15, 1, 3, RADIX_HEX, 1'b0)));
        rows.push_back(char_row(CHAR_ZERO, 1'b1, 1));
        rows.push_back(char_row("7", 1'b0, 1));
        rows.push_back(end_row("8", 1'b0, number(7, 2, 2, RADIX_OCT, 1'b0)));
        rows.push_back(char_row(CHAR_ZERO, 1'b1, 1));
        rows.push_back(end_row(" ", 1'b0, number(0, 1, 1, RADIX_OCT, 1'b0)));
        rows.push_back(char_row(CHAR_ZERO, 1'b1, 1));
        rows.push_back(char_row(CHAR_X_UP, 1'b0, 1));
        rows.push_back(end_row(" ", 1'b0, number(0, 0, 2, RADIX_HEX, 1'b0)));
        rows.push_back(char_row(CHAR_ZERO, 1'b1, 1));
        rows.push_back(char_row("3", 1'b1, 1));
        rows.push_back(end_row(" ", 1'b0, number(3, 1, 1, RADIX_DEC, 1'b0)));
        // prefix that uses up the whole width
        rows.push_back(cfg_row(RADIX_HEX, 16'd2));
        rows.push_back(char_row(CHAR_ZERO, 1'b1, 1));
        rows.push_back(end_row(CHAR_X_LO, 1'b0, number(0, 0, 2, RADIX_HEX, 1'b0)));
        rows.push_back(char_row("F", 1'b1, 1));
        rows.push_back(end_row("F", 1'b0, number(255, 2, 2, RADIX_HEX, 1'b0)));
        rows.push_back(cfg_row(RADIX_HEX, 16'd1));
        rows.push_back(end_row(CHAR_ZERO, 1'b1, number(0, 1, 1, RADIX_HEX, 1'b0)));
        rows.push_back(cfg_row(RADIX_UNARY, 16'd3));
        rows.push_back(char_row(CHAR_ZERO, 1'b1, 1));
        rows.push_back(end_row("1", 1'b0, number(0, 1, 1, RADIX_UNARY, 1'b0)));
        rows.push_back(cfg_row(RADIX_TOP, WIDTH_TOP));
        rows.push_back(char_row("f", 1'b1, 1));
        rows.push_back(end_row(8'hC8, 1'b0, number(15, 1, 1, RADIX_TOP, 1'b0)));
        rows.push_back(cfg_row(RADIX_DEC, WIDTH_ANY));
        rows.push_back(char_row(CHAR_ZERO, 1'b1, 1));
        rows.push_back(end_row(8'h00, 1'b0, number(0, 1, 1, RADIX_DEC, 1'b0)));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                settle();
                set_config(rows[i].radix, rows[i].width);
            end
            else
            begin
                repeat (rows[i].reps)
                    send_char(rows[i].ch, rows[i].fs, rows[i].typed, rows[i].want);
            end
        end
        settle();

        start_count = chars_parsed;
        while (chars_parsed - start_count < RANDOM_CHARS)
        begin
            if (settings_run - 5 < 8)
            begin
                radix_pick = RADIX_PLAN[(settings_run - 5) % 8];
                width_pick = WIDTH_PLAN[(settings_run - 5) % 8];
            end
            else
            begin
                radix_pick = RADIX_BITS'($urandom_range(0, 31));
                width_pick = ($urandom_range(0, 2) == 0) ? WIDTH_ANY
                                                         : WIDTH_BITS'($urandom_range(1, 12));
            end
            set_config(radix_pick, width_pick);
            phase_start = chars_parsed;
            while (chars_parsed - phase_start < PHASE_CHARS)
                send_random_item();
            send_char(" ", 1'b0);
            settle();
        end

        $display("checked %0d numbers from %0d parsed characters over %0d register settings",
                 numbers_checked, chars_parsed, settings_run);
        $display("run covered auto and fixed radixes, prefixes, restarts, width cut-offs %s",
                 "and saturation");
        if (expected_numbers.size() != 0)
            $display("%0d expected results never arrived", expected_numbers.size());
        if (mismatches == 0 && expected_numbers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/aup_pkg.sv
rtl/aup_mac.sv
rtl/aup_out_buf.sv
rtl/ascii_unsigned_integer_parser.sv
sim/tb_ascii_unsigned_integer_parser.sv
